// ===== design/wphq_pkg.sv =====
// Shared types and constants for the worker pool heartbeat queue.
// Field codes, register indexes, reset values and stream widths.
// No dependencies.
package wphq_pkg;

  // Stream payload widths (whole bytes).
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;
  localparam int CFG_DATA_W = 16;

  // Input field positions inside s_tdata.
  localparam int ACTION_LSB = 0;
  localparam int WID_LSB = 2;
  localparam int MSG_LSB = 10;

  typedef logic [1:0] action_t;
  typedef logic [1:0] msg_kind_t;
  typedef logic [2:0] result_kind_t;
  typedef logic [7:0] target_id_t;

  // Input actions.
  localparam action_t ACT_TICK = 2'd0;
  localparam action_t ACT_MSG = 2'd1;
  localparam action_t ACT_REQUEST = 2'd2;

  // Worker message kinds.
  localparam msg_kind_t MSG_READY = 2'd0;
  localparam msg_kind_t MSG_INVALID = 2'd1;
  localparam msg_kind_t MSG_REPLY = 2'd2;

  // Result kinds.
  localparam result_kind_t RES_FORWARD = 3'd0;
  localparam result_kind_t RES_DISPATCH = 3'd1;
  localparam result_kind_t RES_HEARTBEAT = 3'd2;
  localparam result_kind_t RES_INVALID = 3'd3;
  localparam result_kind_t RES_NO_WORKER = 3'd4;
  localparam result_kind_t RES_POOL_FULL = 3'd5;

  // Configuration register indexes.
  localparam logic REG_HB_INTERVAL = 1'b0;
  localparam logic REG_LIVENESS = 1'b1;

  // Reset values.
  localparam logic [15:0] HB_INTERVAL_RESET = 16'd1000;
  localparam logic [3:0] LIVENESS_RESET = 4'd3;
  localparam logic [31:0] NEXT_HB_RESET = 32'd1000;

endpackage

// ===== design/wphq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the idle-worker queue entries. No dependencies.
module wphq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/worker_pool_heartbeat_queue.sv =====
// Idle-worker queue with heartbeat expiry, top level.
// Depends on wphq_pkg and the entry RAM wphq_ram.
//
// The block keeps idle workers in arrival order (least recent message at the
// head) in a circular buffer held in one RAM, each entry a worker id and an
// expiry tick. Each input transfer is handled by a small sequencer that walks
// the RAM one entry at a time through its single read port, and the block
// takes no new item until the walk and the trailing expiry purge are done.
// Per item: a tick sends a heartbeat to every queued worker when a round is
// due; a worker message searches the queue for the worker's entry, moves each
// later entry down to close the gap and appends the worker at the tail, with
// a pool-full result when the queue is full (a forwarded or invalid result
// follows it for a non-ready message); a client request pops the head worker,
// or reports no worker on an empty queue; an unknown action goes straight to
// the purge. Every item ends with the purge, which drops expired head entries.
// Results leave through an output register, so a stalled sink only holds
// the sequencer while a result waits to be taken. Time compares are
// wrap-safe over 32 bits.
module worker_pool_heartbeat_queue #(
  parameter int MAX_WORKERS = 16,
  parameter int ID_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [wphq_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream: action[1:0], worker_id[9:2], msg_kind[11:10], zero fill
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [wphq_pkg::S_DATA_W-1:0]   s_tdata,
  // Output stream: result_kind[2:0], target_id[10:3], zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [wphq_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                            m_tlast
);

  import wphq_pkg::*;

  localparam int SID_W = (ID_BITS < 8) ? ID_BITS : 8;
  localparam int PTR_W = $clog2(MAX_WORKERS);
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);
  localparam int ENT_W = SID_W + 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_HB_RD,
    ST_HB_OUT,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_MSG_OUT,
    ST_POP_RD,
    ST_POP_OUT,
    ST_NO_WORKER,
    ST_PURGE_RD,
    ST_PURGE_CHK
  } state_t;

  state_t             state;
  logic [15:0]        hb_interval;
  logic [3:0]         liveness;
  logic [19:0]        prod;
  logic [31:0]        now_ticks;
  logic [31:0]        next_heartbeat;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  msg_kind_t          kind;
  logic [SID_W-1:0]   wid;
  logic               full_pend;
  result_kind_t       out_kind;
  target_id_t         out_id;
  logic               out_last;

  logic               out_free;
  logic               out_load;
  logic               in_xfer;
  logic [CNT_W-1:0]   rd_off;
  logic [CNT_W-1:0]   wr_off;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wr_addr;
  logic               rd_en;
  logic               wr_en;
  logic [ENT_W-1:0]   wr_data;
  logic [ENT_W-1:0]   rd_data;
  logic [SID_W-1:0]   rd_id;
  logic [31:0]        rd_exp;
  logic [31:0]        exp_diff;
  logic [31:0]        hb_diff;
  logic               idx_is_last;
  logic               shift_more;
  action_t            in_action;

  // Ring index: base plus offset, folded once into the depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [PTR_W+1:0] sum;
    sum = (PTR_W+2)'(base) + (PTR_W+2)'(off);
    if (sum >= (PTR_W+2)'(MAX_WORKERS)) begin
      sum = sum - (PTR_W+2)'(MAX_WORKERS);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign in_action = s_tdata[ACTION_LSB +: 2];
  assign out_free  = !m_tvalid || m_tready;

  assign m_tdata = {(M_DATA_W - 11)'(0), out_id, out_kind};
  assign m_tlast = out_last;

  assign rd_id       = rd_data[ENT_W-1 -: SID_W];
  assign rd_exp      = rd_data[31:0];
  assign exp_diff    = now_ticks - rd_exp;
  assign hb_diff     = now_ticks - next_heartbeat;
  assign idx_is_last = (CNT_W'(idx + 1'b1) == count);
  assign shift_more  = ((CNT_W+1)'(idx) + (CNT_W+1)'(2)) < (CNT_W+1)'(count);

  // Select RAM addresses and strobes for the current step
  always_comb begin
    rd_off   = '0;
    rd_en    = 1'b0;
    wr_off   = idx;
    wr_en    = 1'b0;
    wr_data  = {wid, now_ticks + 32'(prod)};
    out_load = 1'b0;
    unique case (state)
      ST_HB_RD, ST_SRCH_RD: begin
        rd_off = idx;
        rd_en  = 1'b1;
      end
      ST_SHIFT_RD: begin
        rd_off = CNT_W'(idx + 1'b1);
        rd_en  = 1'b1;
      end
      ST_POP_RD, ST_PURGE_RD: begin
        rd_en = 1'b1;
      end
      ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      ST_APPEND: begin
        wr_off = count;
        wr_en  = (count < CNT_W'(MAX_WORKERS));
      end
      ST_HB_OUT, ST_POP_OUT, ST_NO_WORKER: begin
        out_load = out_free;
      end
      ST_MSG_OUT: begin
        out_load = out_free && (full_pend || (kind != MSG_READY));
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = wrap_add(head, rd_off);
  assign wr_addr = wrap_add(head, wr_off);

  wphq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_WORKERS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Sequencer, queue bookkeeping, configuration and output register
  always_ff @(posedge clk) begin
    prod <= 20'(hb_interval) * 20'(liveness);
    if (rst) begin
      state          <= ST_IDLE;
      hb_interval    <= HB_INTERVAL_RESET;
      liveness       <= LIVENESS_RESET;
      now_ticks      <= '0;
      next_heartbeat <= NEXT_HB_RESET;
      head           <= '0;
      count          <= '0;
      idx            <= '0;
      full_pend      <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once its transfer completes
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HB_INTERVAL: hb_interval <= cfg_data[15:0];
          REG_LIVENESS:    liveness <= cfg_data[3:0];
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            wid  <= s_tdata[WID_LSB +: SID_W];
            kind <= s_tdata[MSG_LSB +: 2];
            idx  <= '0;
            case (in_action)
              ACT_TICK: begin
                now_ticks <= now_ticks + 32'd1;
                state     <= ST_TICK;
              end
              ACT_MSG: begin
                state <= (count == '0) ? ST_APPEND : ST_SRCH_RD;
              end
              ACT_REQUEST: begin
                state <= (count == '0) ? ST_NO_WORKER : ST_POP_RD;
              end
              default: begin
                state <= ST_PURGE_RD;
              end
            endcase
          end
        end

        // Heartbeat round when due, then rearm
        ST_TICK: begin
          if (!hb_diff[31]) begin
            next_heartbeat <= now_ticks + 32'(hb_interval);
            state          <= (count == '0) ? ST_PURGE_RD : ST_HB_RD;
          end else begin
            state <= ST_PURGE_RD;
          end
        end

        ST_HB_RD: begin
          state <= ST_HB_OUT;
        end

        ST_HB_OUT: begin
          if (out_free) begin
            out_kind <= RES_HEARTBEAT;
            out_id   <= 8'(rd_id);
            out_last <= idx_is_last;
            if (idx_is_last) begin
              state <= ST_PURGE_RD;
            end else begin
              idx   <= CNT_W'(idx + 1'b1);
              state <= ST_HB_RD;
            end
          end
        end

        // Search for an entry of this worker
        ST_SRCH_RD: begin
          state <= ST_SRCH_CHK;
        end

        ST_SRCH_CHK: begin
          if (rd_id == wid) begin
            if (idx_is_last) begin
              count <= CNT_W'(count - 1'b1);
              state <= ST_APPEND;
            end else begin
              state <= ST_SHIFT_RD;
            end
          end else if (idx_is_last) begin
            state <= ST_APPEND;
          end else begin
            idx   <= CNT_W'(idx + 1'b1);
            state <= ST_SRCH_RD;
          end
        end

        // Close the gap: move each later entry down by one
        ST_SHIFT_RD: begin
          state <= ST_SHIFT_WR;
        end

        ST_SHIFT_WR: begin
          if (shift_more) begin
            idx   <= CNT_W'(idx + 1'b1);
            state <= ST_SHIFT_RD;
          end else begin
            count <= CNT_W'(count - 1'b1);
            state <= ST_APPEND;
          end
        end

        // Append at the tail, or mark the pool full
        ST_APPEND: begin
          if (count < CNT_W'(MAX_WORKERS)) begin
            count     <= CNT_W'(count + 1'b1);
            full_pend <= 1'b0;
          end else begin
            full_pend <= 1'b1;
          end
          state <= ST_MSG_OUT;
        end

        ST_MSG_OUT: begin
          if (full_pend) begin
            if (out_free) begin
              out_kind  <= RES_POOL_FULL;
              out_id    <= 8'(wid);
              out_last  <= (kind == MSG_READY);
              full_pend <= 1'b0;
              if (kind == MSG_READY) begin
                state <= ST_PURGE_RD;
              end
            end
          end else if (kind == MSG_READY) begin
            state <= ST_PURGE_RD;
          end else if (out_free) begin
            out_kind <= (kind == MSG_REPLY) ? RES_FORWARD : RES_INVALID;
            out_id   <= 8'(wid);
            out_last <= 1'b1;
            state    <= ST_PURGE_RD;
          end
        end

        // Pop the head worker for a client request
        ST_POP_RD: begin
          state <= ST_POP_OUT;
        end

        ST_POP_OUT: begin
          if (out_free) begin
            out_kind <= RES_DISPATCH;
            out_id   <= 8'(rd_id);
            out_last <= 1'b1;
            head     <= wrap_add(head, CNT_W'(1));
            count    <= CNT_W'(count - 1'b1);
            state    <= ST_PURGE_RD;
          end
        end

        ST_NO_WORKER: begin
          if (out_free) begin
            out_kind <= RES_NO_WORKER;
            out_id   <= '0;
            out_last <= 1'b1;
            state    <= ST_PURGE_RD;
          end
        end

        // Drop expired entries at the head
        ST_PURGE_RD: begin
          state <= (count == '0) ? ST_IDLE : ST_PURGE_CHK;
        end

        ST_PURGE_CHK: begin
          if (!exp_diff[31]) begin
            head  <= wrap_add(head, CNT_W'(1));
            count <= CNT_W'(count - 1'b1);
            state <= ST_PURGE_RD;
          end else begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
